@@ hdl/lcf_pkg.sv @@
// Package for the layered character frame buffer.
// Holds action codes, default sizes and shared command/status types.
`default_nettype none
package lcf_pkg;
	localparam int SCREEN_WIDTH_DEF  = 80;
	localparam int SCREEN_HEIGHT_DEF = 32;
	localparam int LAYER_COUNT_DEF   = 4;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	localparam logic [2:0] ACT_FILL  = 3'd0;
	localparam logic [2:0] ACT_TEXT  = 3'd1;
	localparam logic [2:0] ACT_CLEAR = 3'd2;
	localparam logic [2:0] ACT_READ  = 3'd3;
	localparam logic [2:0] ACT_EOF   = 3'd4;

	typedef struct packed {
		logic load;      // capture input item
		logic init_step; // reset sweep: write background, clear flag
		logic fill_step; // write fill cell and advance column/row
		logic text_step; // write text cell if in range
		logic clr_step;  // clear layer sweep step
		logic rd_issue;  // issue a layer read
		logic rd_take;   // merge registered read data
		logic eof_issue; // read flag/addr for end-of-frame
		logic eof_take;  // conditional write for end-of-frame
		logic sweep_rst; // zero sweep counter
	} lcf_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic fill_done;
		logic layer_last;
	} lcf_sts_t;
endpackage
`default_nettype wire

@@ hdl/layered_char_framebuffer_top.sv @@
// Layered character frame buffer, top level: streaming ports, APB register,
// controller and datapath. Depends on lcf_pkg, lcf_ctrl, lcf_datapath.
//
// After reset a clearing pass over all SCREEN_WIDTH*SCREEN_HEIGHT*LAYER_COUNT
// cells runs before the first item is taken. One item is in work at a time.
// Once an item is accepted, text writes one cell; read cell issues and merges
// one layer at a time on one memory read port (only one layer when cell_index
// lies outside the canvas); fill steps once per visited cell (at least once);
// clear layer steps once per cell of the layer; end of frame reads and then
// conditionally writes each cell of all layers. The result holds until taken;
// the next item can be accepted in the cycle after.
`default_nettype none
module layered_char_framebuffer_top #(
	parameter int SCREEN_WIDTH  = lcf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = lcf_pkg::SCREEN_HEIGHT_DEF,
	parameter int LAYER_COUNT   = lcf_pkg::LAYER_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// action, pos_x, pos_y, layer, rect_width, rect_height, char_code,
	// is_static, text_offset, cell_index (from bit 0)
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// cell_char, cell_written (from bit 0)
	output logic [15:0]      m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	lcf_pkg::lcf_cmd_t cmd;
	lcf_pkg::lcf_sts_t sts;
	logic [7:0] bg_q;
	logic [7:0] cchar;
	logic       cwr;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {24'b0, bg_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bg_q <= lcf_pkg::SPACE_CHAR;
		else if (psel && penable && pwrite && paddr == 1'b0)
			bg_q <= pwdata[7:0];
	end

	lcf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_action(s_tdata[2:0]), .out_ready(m_tready), .out_valid(m_tvalid),
		.cmd(cmd), .sts(sts)
	);

	lcf_datapath #(
		.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
		.LAYER_COUNT(LAYER_COUNT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .bg_char(bg_q),
		.in_data(s_tdata[72:0]), .cell_char(cchar), .cell_written(cwr)
	);

	assign m_tdata = {7'b0, cwr, cchar};
endmodule
`default_nettype wire

@@ hdl/lcf_datapath.sv @@
// Datapath of the layered character frame buffer: cell memories, address
// counters and composite logic. Depends on lcf_pkg.
`default_nettype none
module lcf_datapath #(
	parameter int SCREEN_WIDTH  = lcf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = lcf_pkg::SCREEN_HEIGHT_DEF,
	parameter int LAYER_COUNT   = lcf_pkg::LAYER_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lcf_pkg::lcf_cmd_t cmd,
	output lcf_pkg::lcf_sts_t     sts,
	input  wire logic [7:0]       bg_char,
	input  wire logic [72:0]      in_data,
	output logic [7:0]            cell_char,
	output logic                  cell_written
);
	localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int TOTAL = CELLS * LAYER_COUNT;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int LW    = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

	logic [7:0] chars_q [TOTAL];
	logic       flags_q [TOTAL];

	logic [2:0]  act_q;
	logic signed [9:0] px_q, py_q;
	logic [LW-1:0] lay_q;
	logic [7:0]  rw_q, rh_q, ch_q;
	logic        st_q;
	logic [11:0] toff_q, cidx_q;

	logic [AW:0]   sweep_q;
	logic [8:0]    xi_q, yi_q;
	logic [LW-1:0] rl_q;
	logic [7:0]    rd_char_s1;
	logic          rd_flag_s1;
	logic [AW-1:0] rd_addr_s1;
	logic [7:0]    acc_q;
	logic signed [22:0] tidx_q;

	logic [2:0] in_lay;
	assign in_lay = in_data[23:21];

	// fill geometry
	logic signed [10:0] col, row;
	assign col = 11'(px_q) + 11'($signed({2'b0, xi_q}));
	assign row = 11'(py_q) + 11'($signed({2'b0, yi_q}));
	logic col_ok, row_ok, row_end, col_end, fill_in;
	assign col_ok  = (col >= 0) && (col < SCREEN_WIDTH);
	assign row_ok  = (row >= 0) && (row < SCREEN_HEIGHT);
	assign col_end = (xi_q + 9'd1 >= {1'b0, rw_q}) || (col + 11'sd1 >= SCREEN_WIDTH);
	assign row_end = (yi_q + 9'd1 >= {1'b0, rh_q}) || (row + 11'sd1 >= SCREEN_HEIGHT);
	assign fill_in = col_ok && row_ok && (rw_q != 0) && (rh_q != 0);

	logic [AW-1:0] fill_addr, base_addr;
	assign base_addr = AW'(lay_q * CELLS);
	assign fill_addr = AW'(base_addr + AW'(row) * AW'(SCREEN_WIDTH) + AW'(col));

	logic text_ok;
	assign text_ok = (tidx_q >= 0) && (tidx_q < CELLS);

	assign sts.sweep_done = (cmd.eof_take || cmd.eof_issue)
		? (sweep_q >= (AW+1)'(TOTAL))
		: ((sweep_q >= (AW+1)'(TOTAL - 1) && !cmd.clr_step) ||
		   (cmd.clr_step && sweep_q >= (AW+1)'(CELLS - 1)));
	assign sts.fill_done  = (rw_q == 0) || (rh_q == 0) || (row >= SCREEN_HEIGHT) ||
		(col_end && row_end);
	assign sts.layer_last = (rl_q == LW'(LAYER_COUNT - 1)) || (cidx_q >= CELLS);

	// single write port shared by all writing sequences
	logic          wr_en, wr_flag_en, wr_flag;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_char;

	always_comb begin
		wr_en      = 1'b0;
		wr_flag_en = 1'b0;
		wr_flag    = 1'b0;
		wr_addr    = '0;
		wr_char    = bg_char;
		if (cmd.init_step) begin
			wr_en      = 1'b1;
			wr_flag_en = 1'b1;
			wr_addr    = AW'(sweep_q);
		end else if (cmd.fill_step && fill_in) begin
			wr_en      = 1'b1;
			wr_flag_en = 1'b1;
			wr_flag    = st_q;
			wr_addr    = fill_addr;
			wr_char    = ch_q;
		end else if (cmd.text_step && text_ok) begin
			wr_en      = 1'b1;
			wr_flag_en = 1'b1;
			wr_flag    = st_q;
			wr_addr    = AW'(base_addr + AW'(tidx_q));
			wr_char    = ch_q;
		end else if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = AW'(base_addr + AW'(sweep_q));
		end else if (cmd.eof_take && !rd_flag_s1) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= in_data[2:0];
			px_q   <= 10'($signed(in_data[11:3]));
			py_q   <= 10'($signed(in_data[20:12]));
			lay_q  <= ({1'b0, in_lay} >= 4'(LAYER_COUNT)) ? LW'(LAYER_COUNT - 1) : LW'(in_lay);
			rw_q   <= in_data[31:24];
			rh_q   <= in_data[39:32];
			ch_q   <= in_data[47:40];
			st_q   <= in_data[48];
			toff_q <= in_data[60:49];
			cidx_q <= in_data[72:61];
			tidx_q <= 23'($signed(in_data[11:3])) +
				23'($signed(in_data[20:12])) * 23'(SCREEN_WIDTH) +
				23'({11'b0, in_data[60:49]});
		end
		if (wr_en)
			chars_q[wr_addr] <= wr_char;
		if (wr_flag_en)
			flags_q[wr_addr] <= wr_flag;
		if (cmd.rd_issue)
			rd_char_s1 <= chars_q[AW'(rl_q * CELLS + cidx_q)];
		if (cmd.eof_issue) begin
			rd_flag_s1 <= flags_q[AW'(sweep_q)];
			rd_addr_s1 <= AW'(sweep_q);
		end
	end

	logic [7:0] act_out;
	assign act_out = (act_q == lcf_pkg::ACT_READ) ? acc_q : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			xi_q <= '0;
			yi_q <= '0;
			rl_q <= '0;
			acc_q <= lcf_pkg::SPACE_CHAR;
			cell_char <= '0;
			cell_written <= 1'b0;
		end else begin
			if (cmd.sweep_rst)
				sweep_q <= '0;
			else if (cmd.init_step || cmd.clr_step || cmd.eof_issue)
				sweep_q <= sweep_q + 1'b1;
			if (cmd.load) begin
				xi_q <= '0;
				yi_q <= '0;
				rl_q <= '0;
				acc_q <= lcf_pkg::SPACE_CHAR;
			end
			if (cmd.fill_step) begin
				if (col_end) begin
					xi_q <= '0;
					yi_q <= yi_q + 9'd1;
				end else
					xi_q <= xi_q + 9'd1;
			end
			if (cmd.rd_take) begin
				if (cidx_q < CELLS && rd_char_s1 != bg_char &&
					rd_char_s1 != lcf_pkg::SPACE_CHAR)
					acc_q <= rd_char_s1;
				rl_q <= rl_q + 1'b1;
			end
			cell_char    <= act_out;
			cell_written <= (act_q == lcf_pkg::ACT_TEXT) && text_ok;
		end
	end
endmodule
`default_nettype wire

@@ hdl/lcf_ctrl.sv @@
// Controller state machine of the layered character frame buffer.
// Sequences reset sweep, actions and output handshake. Depends on lcf_pkg.
`default_nettype none
module lcf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        in_action,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output lcf_pkg::lcf_cmd_t      cmd,
	input  wire lcf_pkg::lcf_sts_t sts
);
	localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_DEC = 4'd2, S_FILL = 4'd3,
		S_TEXT = 4'd4, S_CLR = 4'd5, S_RDI = 4'd6, S_RDT = 4'd7, S_EOFI = 4'd8,
		S_EOFT = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11;

	logic [3:0] state_q, state_d;
	logic [2:0] act_q;
	logic       acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.sweep_done) begin
					cmd.sweep_rst = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_IDLE: if (acc) begin
				cmd.load = 1'b1;
				cmd.sweep_rst = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: case (act_q)
				lcf_pkg::ACT_FILL:  state_d = S_FILL;
				lcf_pkg::ACT_TEXT:  state_d = S_TEXT;
				lcf_pkg::ACT_CLEAR: state_d = S_CLR;
				lcf_pkg::ACT_READ:  state_d = S_RDI;
				lcf_pkg::ACT_EOF:   state_d = S_EOFI;
				default:            state_d = S_FIN;
			endcase
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_done) state_d = S_FIN;
			end
			S_TEXT: begin
				cmd.text_step = 1'b1;
				state_d = S_FIN;
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.sweep_done) begin
					cmd.sweep_rst = 1'b1;
					state_d = S_FIN;
				end
			end
			S_RDI: begin
				cmd.rd_issue = 1'b1;
				state_d = S_RDT;
			end
			S_RDT: begin
				cmd.rd_take = 1'b1;
				state_d = sts.layer_last ? S_FIN : S_RDI;
			end
			S_EOFI: begin
				cmd.eof_issue = 1'b1;
				state_d = S_EOFT;
			end
			S_EOFT: begin
				cmd.eof_take = 1'b1;
				if (sts.sweep_done) begin
					cmd.sweep_rst = 1'b1;
					state_d = S_FIN;
				end else
					state_d = S_EOFI;
			end
			S_FIN: state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			act_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc) act_q <= in_action;
		end
	end
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench for layered_char_framebuffer_top: a directed table, then random items in phases.
// Each item is checked against a predictor in this file; depends on lcf_pkg and the RTL.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = lcf_pkg::SCREEN_WIDTH_DEF;
	localparam int H = lcf_pkg::SCREEN_HEIGHT_DEF;
	localparam int L = lcf_pkg::LAYER_COUNT_DEF;
	localparam int CELLS = W * H;
	localparam logic [2:0] A_FILL  = lcf_pkg::ACT_FILL;
	localparam logic [2:0] A_TEXT  = lcf_pkg::ACT_TEXT;
	localparam logic [2:0] A_CLEAR = lcf_pkg::ACT_CLEAR;
	localparam logic [2:0] A_READ  = lcf_pkg::ACT_READ;
	localparam logic [2:0] A_EOF   = lcf_pkg::ACT_EOF;
	localparam logic [7:0] SPACE   = lcf_pkg::SPACE_CHAR;
	localparam logic [2:0] ACT_NONE = 3'd5;
	localparam int WATCH_LIMIT = 400000;

	typedef struct {
		logic [2:0]  action;
		logic [8:0]  pos_x;
		logic [8:0]  pos_y;
		logic [2:0]  layer;
		logic [7:0]  rect_w;
		logic [7:0]  rect_h;
		logic [7:0]  char_code;
		logic        is_static;
		logic [11:0] text_offset;
		logic [11:0] cell_index;
		bit          typed;
		logic [7:0]  typed_char;
		logic        typed_written;
	} cmd_t;

	typedef struct {
		logic [7:0] cell_char;
		logic       cell_written;
	} cell_res_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0;
	logic [79:0] s_tdata = '0;
	logic s_tready, m_tvalid;
	logic [15:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0, paddr = 0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	layered_char_framebuffer_top u_dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	logic [7:0] shadow_chars [CELLS*L];
	bit         shadow_flags [CELLS*L];
	logic [7:0] shadow_bg;
	cell_res_t  pending_cells [$];
	cmd_t       typed_rows [$];
	int errors = 0, mismatches = 0, n_in = 0, n_out = 0, idle_cycles = 0;
	int send_idle = 0, recv_idle = 0;
	bit hold_off = 0, done = 0;

	function automatic logic [79:0] pack_cmd(cmd_t c);
		logic [79:0] v;
		v = {7'b0, c.cell_index, c.text_offset, c.is_static, c.char_code, c.rect_h, c.rect_w,
			c.layer, c.pos_y, c.pos_x, c.action};
		return v;
	endfunction

	function automatic cell_res_t apply_cmd(logic [79:0] d);
		cell_res_t r;
		int px, py, lb, rw, rh, idx, row, col, ly;
		logic [2:0] act;
		logic [7:0] ch;
		logic st;
		int cidx;
		act = d[2:0];
		px = $signed(d[11:3]);
		py = $signed(d[20:12]);
		lb = (d[23:21] >= L) ? L - 1 : d[23:21];
		lb = lb * CELLS;
		rw = d[31:24];
		rh = d[39:32];
		ch = d[47:40];
		st = d[48];
		cidx = d[72:61];
		r.cell_char = 0;
		r.cell_written = 0;
		case (act)
			A_FILL: begin
				for (int y = 0; y < rh; y++) begin
					row = py + y;
					if (row >= H) break;
					if (row < 0) continue;
					for (int x = 0; x < rw; x++) begin
						col = px + x;
						if (col >= W) break;
						if (col < 0) continue;
						shadow_chars[lb + row*W + col] = ch;
						shadow_flags[lb + row*W + col] = st;
					end
				end
			end
			A_TEXT: begin
				idx = px + py * W + int'(d[60:49]);
				if (idx >= 0 && idx < CELLS) begin
					shadow_chars[lb + idx] = ch;
					shadow_flags[lb + idx] = st;
					r.cell_written = 1;
				end
			end
			A_CLEAR: for (int i = 0; i < CELLS; i++) shadow_chars[lb + i] = shadow_bg;
			A_READ: begin
				r.cell_char = SPACE;
				if (cidx < CELLS)
					for (ly = 0; ly < L; ly++)
						if (shadow_chars[ly*CELLS + cidx] != shadow_bg &&
							shadow_chars[ly*CELLS + cidx] != SPACE)
							r.cell_char = shadow_chars[ly*CELLS + cidx];
			end
			A_EOF: for (int i = 0; i < CELLS*L; i++)
				if (!shadow_flags[i]) shadow_chars[i] = shadow_bg;
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [7:0] e, logic [7:0] a);
		errors++;
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %0s: expected %0h got %0h (item %0d)", what, e, a, n_out);
	endtask

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pending_cells.push_back(apply_cmd(s_tdata));
			n_in++;
		end
		if (m_tvalid && m_tready) begin
			if (pending_cells.size() == 0) begin
				errors++;
				$display("result with nothing expected: %0h", m_tdata);
			end else begin
				cell_res_t e;
				e = pending_cells.pop_front();
				if (m_tdata[7:0] !== e.cell_char) report("cell_char", e.cell_char, m_tdata[7:0]);
				if (m_tdata[8] !== e.cell_written)
					report("cell_written", e.cell_written, m_tdata[8]);
				if (typed_rows.size() > 0 && n_out < typed_rows.size() && typed_rows[n_out].typed)
					if (m_tdata[7:0] !== typed_rows[n_out].typed_char ||
						m_tdata[8] !== typed_rows[n_out].typed_written)
						report("table row", typed_rows[n_out].typed_char, m_tdata[7:0]);
			end
			n_out++;
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCH_LIMIT && !done) begin
			$display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_cmd(cmd_t c);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= pack_cmd(c);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		@(posedge clk);
		s_tvalid <= 0;
		while (pending_cells.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_bg(logic [7:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= {24'h0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		shadow_bg = v;
	endtask

	function automatic cmd_t mk(logic [2:0] a, int px, int py, int ly, int rw, int rh, int ch,
			bit st, int toff, int cidx, bit t = 0, int tc = 0, bit tw = 0);
		cmd_t c;
		c.action = a; c.pos_x = px; c.pos_y = py; c.layer = ly; c.rect_w = rw; c.rect_h = rh;
		c.char_code = ch; c.is_static = st; c.text_offset = toff; c.cell_index = cidx;
		c.typed = t; c.typed_char = tc; c.typed_written = tw;
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int k;
		k = $urandom_range(99);
		c = mk(A_TEXT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		if ($urandom_range(3) == 0) c.char_code = ($urandom_range(1)) ? shadow_bg : SPACE;
		if (k < 36) begin
			c.action = A_TEXT;
			if ($urandom_range(3) != 0) begin
				c.pos_x = $urandom_range(W - 1);
				c.pos_y = $urandom_range(H - 1);
				c.text_offset = $urandom_range(40);
			end
		end else if (k < 72) begin
			c.action = A_READ;
			if ($urandom_range(4) != 0) c.cell_index = $urandom_range(CELLS - 1);
		end else if (k < 90) begin
			c.action = A_FILL;
			c.pos_x = int'($urandom_range(110)) - 15;
			c.pos_y = int'($urandom_range(45)) - 10;
			if ($urandom_range(29) != 0) begin
				c.rect_w = $urandom_range(12);
				c.rect_h = $urandom_range(6);
			end
		end else if (k < 94) c.action = A_CLEAR;
		else if (k < 97) c.action = A_EOF;
		else c.action = 3'($urandom_range(7, 5));
		return c;
	endfunction

	initial begin
		cmd_t rows [$];
		int random_left;
		shadow_bg = SPACE;
		for (int i = 0; i < CELLS*L; i++) begin
			shadow_chars[i] = SPACE;
			shadow_flags[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1;

		rows.push_back(mk(A_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, SPACE, 0));
		rows.push_back(mk(A_TEXT, 0, 0, 7, 0, 0, 8'h41, 1, 0, 0, 1, 0, 1));
		rows.push_back(mk(A_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h41, 0));
		rows.push_back(mk(A_TEXT, -1, 0, 0, 0, 0, 8'h42, 0, 0, 0, 1, 0, 0));
		rows.push_back(mk(A_TEXT, -256, -256, 0, 0, 0, 8'h42, 0, 4095, 0, 1, 0, 0));
		rows.push_back(mk(A_TEXT, 255, 255, 0, 0, 0, 8'h42, 0, 4095, 0, 1, 0, 0));
		rows.push_back(mk(A_TEXT, 79, 31, 2, 0, 0, 8'hFF, 0, 0, 0, 1, 0, 1));
		rows.push_back(mk(A_TEXT, 79, 31, 2, 0, 0, 8'hFF, 0, 1, 0, 1, 0, 0));
		rows.push_back(mk(A_TEXT, 79, 0, 1, 0, 0, 8'h43, 1, 1, 0, 1, 0, 1));
		rows.push_back(mk(A_READ, 0, 0, 0, 0, 0, 0, 0, 0, 80));
		rows.push_back(mk(A_READ, 0, 0, 0, 0, 0, 0, 0, 0, CELLS - 1));
		rows.push_back(mk(A_FILL, -3, -2, 1, 8, 5, 8'h2A, 0, 0, 0, 1, 0, 0));
		rows.push_back(mk(A_FILL, 76, 29, 3, 255, 255, 8'h00, 1, 0, 0, 1, 0, 0));
		rows.push_back(mk(A_FILL, 5, 5, 0, 0, 9, 8'h2B, 1, 0, 0, 1, 0, 0));
		rows.push_back(mk(A_FILL, -256, -256, 0, 255, 255, 8'h2C, 0, 0, 0, 1, 0, 0));
		rows.push_back(mk(A_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(A_READ, 0, 0, 0, 0, 0, 0, 0, 0, 2000));
		rows.push_back(mk(A_CLEAR, 0, 0, 6, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		rows.push_back(mk(A_READ, 0, 0, 0, 0, 0, 0, 0, 0, CELLS - 1));
		rows.push_back(mk(A_EOF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		rows.push_back(mk(A_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(A_READ, 0, 0, 0, 0, 0, 0, 0, 0, 81));
		rows.push_back(mk(3'd7, 255, 255, 7, 255, 255, 255, 1, 4095, 4095, 1, 0, 0));
		rows.push_back(mk(ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		typed_rows = rows;
		foreach (rows[i]) send_cmd(rows[i]);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 82; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 82; end
				default: begin send_idle = 14; recv_idle = 14; end
			endcase
			case (ph)
				1: set_bg(8'h00);
				3: set_bg(8'hFF);
				5: set_bg($urandom);
				7: set_bg(SPACE);
				default: ;
			endcase
			if (ph == 4) fork
				begin
					hold_off = 1;
					repeat (600) @(posedge clk);
					hold_off = 0;
				end
			join_none
			random_left = 85;
			while (random_left > 0) begin
				send_cmd(rand_cmd());
				random_left--;
			end
			drain();
		end

		done = 1;
		$display("covered %0d items in, %0d results out, eight phases of idling and background",
			n_in, n_out);
		$display("with a long receiver hold-off; %0d mismatches", mismatches);
		if (errors == 0 && pending_cells.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/lcf_pkg.sv
hdl/lcf_datapath.sv
hdl/lcf_ctrl.sv
hdl/layered_char_framebuffer_top.sv
test/tb.sv
